// File: sv/pfsa_pkg.sv
// Package: widths, shared types and bit-search helpers for the slot allocator.
package pfsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = 11;
    localparam int WORD_W    = 32;
    localparam int ROWS      = MAX_SLOTS / WORD_W;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int IDX_W     = ROW_W + BIT_W;

    localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = SLOT_W'(1024);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT       = SLOT_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_LOWER,
        ST_PEND
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_W-1:0]  rd_addr;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              halted;
        logic [SLOT_W-1:0] granted_total;
        logic [SLOT_W-1:0] granted_slot;
        logic              granted;
    } result_t;

    // Highest set bit of a word; zero when none.
    function automatic logic [BIT_W-1:0] hi_bit_word(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
                pos = BIT_W'(i);
        end
        return pos;
    endfunction

    // Highest set bit across the row summary; zero when none.
    function automatic logic [ROW_W-1:0] hi_bit_row(input logic [ROWS-1:0] v);
        logic [ROW_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            if (v[i])
                pos = ROW_W'(i);
        end
        return pos;
    endfunction

endpackage

// File: sv/pfsa_row_mem.sv
// Taken-bit row memory with per-row valid flags; unwritten rows read as all free.
module pfsa_row_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pfsa_pkg::mem_req_t         req,
    output logic [pfsa_pkg::WORD_W-1:0] rd_data
);
    import pfsa_pkg::*;

    logic [WORD_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_word_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                row_valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_valid_reg <= row_valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// File: sv/pfsa_ctrl.sv
// Search sequencer: row lookup, summary fallback, claim and write-back.
module pfsa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [pfsa_pkg::SLOT_W-1:0] upper_slot,
    input  logic [pfsa_pkg::SLOT_W-1:0] slot_count,
    output pfsa_pkg::mem_req_t          mem_req,
    input  logic [pfsa_pkg::WORD_W-1:0] rd_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pfsa_pkg::result_t           res
);
    import pfsa_pkg::*;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [ROWS-1:0]   full_reg, full_next;
    logic              halted_reg, halted_next;
    logic [SLOT_W-1:0] total_reg, total_next;
    result_t           res_reg, res_next;

    logic [SLOT_W-1:0] eff_count;
    logic [SLOT_W-1:0] upper_sat;
    logic [SLOT_W-1:0] pos;
    logic [WORD_W-1:0] cand;
    logic [BIT_W-1:0]  hb;
    logic [ROWS-1:0]   lower_rows;
    logic [WORD_W-1:0] new_word;
    logic [SLOT_W-1:0] claim_slot;
    logic              accept;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_PEND);
    assign res       = res_reg;

    always_comb
    begin
        eff_count  = (slot_count > SLOT_LIMIT) ? SLOT_LIMIT : slot_count;
        upper_sat  = (upper_slot > eff_count) ? eff_count : upper_slot;
        pos        = upper_sat - SLOT_W'(1);
        if (state_reg == ST_ROW)
            cand = ~rd_data & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - bit_reg));
        else
            cand = ~rd_data;
        hb         = hi_bit_word(cand);
        new_word   = rd_data | (WORD_W'(1) << hb);
        lower_rows = ~full_reg & ((ROWS'(1) << row_reg) - ROWS'(1));
        claim_slot = SLOT_W'({row_reg, hb}) + SLOT_W'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (halted_reg || upper_sat == '0)
                        state_next = ST_PEND;
                    else
                        state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (cand != '0 || lower_rows == '0)
                    state_next = ST_PEND;
                else
                    state_next = ST_LOWER;
            end
            ST_LOWER: state_next = ST_PEND;
            ST_PEND:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb
    begin
        row_next    = row_reg;
        bit_next    = bit_reg;
        full_next   = full_reg;
        halted_next = halted_reg;
        total_next  = total_reg;
        res_next    = res_reg;
        mem_req     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (halted_reg || upper_sat == '0)
                    begin
                        halted_next            = 1'b1;
                        res_next.granted       = 1'b0;
                        res_next.granted_slot  = '0;
                        res_next.granted_total = total_reg;
                        res_next.halted        = 1'b1;
                    end
                    else
                    begin
                        row_next        = pos[IDX_W-1:BIT_W];
                        bit_next        = pos[BIT_W-1:0];
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = pos[IDX_W-1:BIT_W];
                    end
                end
            end
            ST_ROW, ST_LOWER:
            begin
                if (cand != '0)
                begin
                    mem_req.wr_en          = 1'b1;
                    mem_req.wr_addr        = row_reg;
                    mem_req.wr_data        = new_word;
                    full_next[row_reg]     = &new_word;
                    total_next             = total_reg + SLOT_W'(1);
                    res_next.granted       = 1'b1;
                    res_next.granted_slot  = claim_slot;
                    res_next.granted_total = total_reg + SLOT_W'(1);
                    res_next.halted        = 1'b0;
                end
                else if (state_reg == ST_ROW && lower_rows != '0)
                begin
                    // Drop to the highest lower row that still has a free slot
                    row_next        = hi_bit_row(lower_rows);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = hi_bit_row(lower_rows);
                end
                else
                begin
                    halted_next            = 1'b1;
                    res_next.granted       = 1'b0;
                    res_next.granted_slot  = '0;
                    res_next.granted_total = total_reg;
                    res_next.halted        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            full_reg   <= '0;
            halted_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            full_reg   <= full_next;
            halted_reg <= halted_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    a_wr_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == ST_ROW || state_reg == ST_LOWER))
        else $error("row write outside a search step");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted_reg) |-> halted_reg)
        else $error("halt flag cleared without reset");

    a_grant_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.granted) |-> !res_reg.halted)
        else $error("granted result marked halted");

    a_lower_row_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOWER) |-> (rd_data != {WORD_W{1'b1}}))
        else $error("fallback row has no free slot");

endmodule

// File: sv/predecessor_free_slot_allocator_top.sv
// Top level: stream ports, slot count register, output register and search core.
// Flow: a request is accepted in IDLE and its row read; ROW searches that row, LOWER
//   searches a fallback lower row, and PEND holds the result until the output takes it.
// A refused request goes straight from IDLE to PEND. One request is in flight: a new
//   request is taken only once the core is back in IDLE.
// Reset (rst_n, async low): all slots free, halt flag and grant count cleared, slot
//   count 1024; memory rows carry valid flags, so no clearing pass is needed.
module predecessor_free_slot_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,    // slot_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [10:0] upper_slot, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // [0] granted, [11:1] granted_slot,
                                        // [22:12] granted_total, [23] halted
);
    import pfsa_pkg::*;

    logic [SLOT_W-1:0] slot_count_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] rd_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    // Hold the slot count; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_count_reg <= SLOT_COUNT_RESET;
        else if (cfg_wr_en)
            slot_count_reg <= cfg_wr_data;
    end

    pfsa_row_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    pfsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .upper_slot (s_tdata[SLOT_W-1:0]),
        .slot_count (slot_count_reg),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: take a finished result whenever the slot is empty or
    // its transfer completes this cycle; the core stalls in PEND while it cannot hand a result over.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
